// ===== rtl/ubef_pkg.sv =====
// Shared types and constants for the bulk endpoint finder.
// Beat payload structs, walk state and end status codes; no dependencies.
`timescale 1ns / 1ps

package ubef_pkg;

  localparam logic [7:0] MaxDescLen   = 8'd16;
  localparam logic [7:0] TypeEndpoint = 8'd5;
  localparam logic [1:0] AttrBulk     = 2'd2;
  localparam logic [7:0] MinMatchLen  = 8'd4;
  localparam logic [8:0] PosMax       = 9'h1FF;
  localparam logic [8:0] TotalPos     = 9'd2;

  typedef enum logic [1:0] {
    END_TOTAL = 2'd0,
    END_LONG  = 2'd1,
    END_ZERO  = 2'd2,
    END_EARLY = 2'd3
  } end_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic [3:0] port_index;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [3:0] in_ep_first;
    logic [3:0] in_ep_second;
    logic [3:0] out_ep_first;
    logic [3:0] out_ep_second;
    logic [3:0] target_port;
    logic [1:0] end_status;
  } result_t;

  typedef struct packed {
    logic [8:0]      byte_pos;
    logic [8:0]      next_desc_start;
    logic [7:0]      total_len;
    logic [7:0]      cur_desc_len;
    logic [7:0]      cur_desc_type;
    logic [7:0]      cur_ep_addr;
    logic [3:0][3:0] ep_slots;
    logic            in_seen;
    logic            out_seen;
    logic [3:0]      latched_port;
    logic            walk_active;
  } walk_state_t;

endpackage

// ===== rtl/ubef_walk.sv =====
// Next-state logic of the descriptor walk for one byte beat.
// Depends on ubef_pkg for the state, beat and result types.
`timescale 1ns / 1ps

module ubef_walk import ubef_pkg::*; (
  input  walk_state_t state,
  input  item_t       item,
  output walk_state_t state_next,
  output logic        fire,
  output result_t     result
);

  walk_state_t s;
  logic        done;
  end_status_t status;
  logic [8:0]  pos;
  logic        known;
  logic [9:0]  diff;
  logic        k_ok;
  logic [8:0]  k;
  logic [8:0]  nxt;

  always_comb begin
    s      = state;
    done   = 1'b0;
    status = END_TOTAL;
    pos    = state.byte_pos;
    known  = 1'b0;
    diff   = '0;
    k_ok   = 1'b0;
    k      = '0;
    nxt    = '0;

    if (item.start_req) begin
      s              = '0;
      s.latched_port = item.port_index;
      s.walk_active  = 1'b1;
    end

    if (s.walk_active) begin
      pos = s.byte_pos;
      if (pos != PosMax) begin
        s.byte_pos = pos + 9'd1;
      end
      known = (pos >= TotalPos);
      diff  = {1'b0, pos} - {1'b0, s.next_desc_start};
      k_ok  = !diff[9];
      k     = diff[8:0];

      if (pos == TotalPos) begin
        s.total_len = item.data_byte;
        if ((item.data_byte == 8'd0) || (s.next_desc_start >= {1'b0, item.data_byte})) begin
          done   = 1'b1;
          status = END_TOTAL;
        end
      end

      if (!done) begin
        if (k_ok && (k == 9'd0)) begin
          s.cur_desc_len = item.data_byte;
        end else if (k_ok && (k == 9'd1)) begin
          s.cur_desc_type = item.data_byte;
        end else if (k_ok && (k == 9'd2)) begin
          s.cur_ep_addr = item.data_byte;
        end

        if (s.cur_desc_len == 8'd0) begin
          if (known) begin
            done   = 1'b1;
            status = END_ZERO;
          end
        end else if (s.cur_desc_len < MinMatchLen) begin
          if (k_ok && (k == ({1'b0, s.cur_desc_len} - 9'd1))) begin
            nxt               = s.next_desc_start + {1'b0, s.cur_desc_len};
            s.next_desc_start = nxt;
            if (known && (nxt >= {1'b0, s.total_len})) begin
              done   = 1'b1;
              status = END_TOTAL;
            end
          end
        end else if (k_ok && (k == 9'd3)) begin
          if ((s.cur_desc_type == TypeEndpoint) && (item.data_byte[1:0] == AttrBulk)) begin
            if (s.cur_ep_addr[7]) begin
              s.ep_slots[s.in_seen ? 2'd1 : 2'd0] = s.cur_ep_addr[3:0];
              s.in_seen = 1'b1;
            end else begin
              s.ep_slots[s.out_seen ? 2'd3 : 2'd2] = s.cur_ep_addr[3:0];
              s.out_seen = 1'b1;
            end
          end
          if (s.cur_desc_len > MaxDescLen) begin
            done   = 1'b1;
            status = END_LONG;
          end else begin
            nxt               = s.next_desc_start + {1'b0, s.cur_desc_len};
            s.next_desc_start = nxt;
            if (nxt >= {1'b0, s.total_len}) begin
              done   = 1'b1;
              status = END_TOTAL;
            end
          end
        end

        if (!done && item.last) begin
          done   = 1'b1;
          status = END_EARLY;
        end
      end

      if (done) begin
        s.walk_active = 1'b0;
      end
    end
  end

  assign state_next           = s;
  assign fire                 = done;
  assign result.in_ep_first   = s.ep_slots[0];
  assign result.in_ep_second  = s.ep_slots[1];
  assign result.out_ep_first  = s.ep_slots[2];
  assign result.out_ep_second = s.ep_slots[3];
  assign result.target_port   = s.latched_port;
  assign result.end_status    = status;

endmodule

// ===== rtl/usb_bulk_endpoint_finder.sv =====
// Top level of the bulk endpoint finder: input register, walk state, result register.
// Depends on ubef_pkg and ubef_walk.
`timescale 1ns / 1ps

// Walks a USB configuration descriptor set delivered one byte per beat and reports the
// bulk IN and OUT endpoint numbers in one result beat when the walk ends (total length
// reached, a descriptor longer than 16 bytes, a zero length, or last seen early). A byte
// beat is accepted every cycle. The byte sits in the input register while the walk logic
// makes the whole per-byte decision. The walk state and the result register load together
// at the clock edge on which the input register advances, so the result beat is offered
// once the byte that ends the walk leaves the input register. While a result beat waits for
// result_ready, the byte in the input register is held whether or not it ends a walk.
// item_ready then drops, so the input stalls until the result drains.

module usb_bulk_endpoint_finder import ubef_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic        s1_valid;
  item_t       s1_item;
  walk_state_t state;
  walk_state_t state_next;
  logic        fire;
  result_t     res_next;
  logic        advance;

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  ubef_walk u_walk (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .fire       (fire),
    .result     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
        if (fire) begin
          result_valid <= 1'b1;
        end
      end
    end
    if (advance && fire) begin
      result <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_fire_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (advance && fire) |=> !state.walk_active)
    else $error("walk still active after result");

  a_in_slots_empty: assert property (@(posedge clk) disable iff (rst)
    !state.in_seen |-> (state.ep_slots[0] == 4'd0) && (state.ep_slots[1] == 4'd0))
    else $error("IN slot filled without IN match");

  a_out_slots_empty: assert property (@(posedge clk) disable iff (rst)
    !state.out_seen |-> (state.ep_slots[2] == 4'd0) && (state.ep_slots[3] == 4'd0))
    else $error("OUT slot filled without OUT match");

  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(advance && fire))
    else $error("result beat without walk end");
`endif

endmodule
